// ===== hw/rtl/llca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// llca_pkg
// Shared types and constants for the line-line closest approach core.
// ---------------------------------------------------------------------------
package llca_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 32;

    // Arithmetic widths, derived from the coordinate width (R_W also from FRAC_BITS).
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int LO_W   = DOT_W / 2;
    localparam int HI_W   = DOT_W - LO_W;
    localparam int PP_W   = 2 * HI_W + 2;
    localparam int WP_W   = 2 * DOT_W;
    localparam int WD_W   = WP_W + 1;
    localparam int R_W    = WD_W + FRAC_BITS + 34;

    localparam logic [OUT_W-1:0] HALF_FX = {{(OUT_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_NORMAL   = 2'd0,
        STATUS_ZERO_LEN = 2'd1,
        STATUS_PARALLEL = 2'd2
    } llca_status_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] line_a_start_x;
        logic signed [COORD_BITS-1:0] line_a_start_y;
        logic signed [COORD_BITS-1:0] line_a_start_z;
        logic signed [COORD_BITS-1:0] line_a_end_x;
        logic signed [COORD_BITS-1:0] line_a_end_y;
        logic signed [COORD_BITS-1:0] line_a_end_z;
        logic signed [COORD_BITS-1:0] line_b_start_x;
        logic signed [COORD_BITS-1:0] line_b_start_y;
        logic signed [COORD_BITS-1:0] line_b_start_z;
        logic signed [COORD_BITS-1:0] line_b_end_x;
        logic signed [COORD_BITS-1:0] line_b_end_y;
        logic signed [COORD_BITS-1:0] line_b_end_z;
    } llca_req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] param_a;
        logic signed [OUT_W-1:0] param_b;
        llca_status_t            status;
        logic                    saturated;
    } llca_rsp_t;

    // Four partial products of one split multiplication.
    typedef struct packed {
        logic signed [PP_W-1:0] hh;
        logic signed [PP_W-1:0] hl;
        logic signed [PP_W-1:0] lh;
        logic signed [PP_W-1:0] ll;
    } llca_pp_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [R_W-1:0]   rem;
        logic [R_W-1:0]   den;
        logic [OUT_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } llca_div_t;

    typedef struct packed {
        logic degen;
        logic par;
    } llca_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_line_closest_approach_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// line_line_closest_approach_core
// Closest-approach parameters of two 3D lines in signed Q16.16, saturated.
// ---------------------------------------------------------------------------
// From the edge that accepts a request to the edge that takes its result, the
// request passes seven arithmetic stages, one overflow check, one stage per quotient
// bit (32) and an output register. Throughput: one request per cycle, busy is
// always low. The receiver cannot stall; results appear with a one-cycle done strobe.
// Reset clears only the valid bits of the pipeline.
module line_line_closest_approach_core
    import llca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire llca_req_t req,
    output logic           done,
    output llca_rsp_t      rsp
);

    localparam int NPAIR = 6;
    localparam int PA_IDX [NPAIR] = '{0, 2, 4, 3, 4, 2};
    localparam int PB_IDX [NPAIR] = '{1, 2, 2, 1, 0, 3};

    function automatic llca_pp_t split_mul(input logic signed [DOT_W-1:0] a,
                                           input logic signed [DOT_W-1:0] b);
        logic signed [HI_W-1:0] ah;
        logic signed [HI_W-1:0] bh;
        logic signed [LO_W:0]   al;
        logic signed [LO_W:0]   bl;
        llca_pp_t               r;
        ah   = a[DOT_W-1:LO_W];
        bh   = b[DOT_W-1:LO_W];
        al   = {1'b0, a[LO_W-1:0]};
        bl   = {1'b0, b[LO_W-1:0]};
        r.hh = PP_W'(ah) * PP_W'(bh);
        r.hl = PP_W'(ah) * PP_W'(bl);
        r.lh = PP_W'(al) * PP_W'(bh);
        r.ll = PP_W'(al) * PP_W'(bl);
        return r;
    endfunction

    function automatic logic signed [WP_W-1:0] join_pp(input llca_pp_t p);
        logic signed [WP_W-1:0] mid;
        mid = WP_W'(p.hl) + WP_W'(p.lh);
        return (WP_W'(p.hh) <<< (2 * LO_W)) + (mid <<< LO_W) + WP_W'(p.ll);
    endfunction

    function automatic llca_div_t div_init(input logic signed [WD_W-1:0] num,
                                           input logic signed [WD_W-1:0] den);
        logic [WD_W-1:0] mn;
        logic [WD_W-1:0] md;
        llca_div_t       r;
        mn    = num[WD_W-1] ? WD_W'(-num) : WD_W'(num);
        md    = den[WD_W-1] ? WD_W'(-den) : WD_W'(den);
        r.rem = (R_W'(mn) << (FRAC_BITS + 1)) + R_W'(md);
        r.den = R_W'(md) << 1;
        r.quo = '0;
        r.neg = num[WD_W-1] ^ den[WD_W-1];
        r.ovf = 1'b0;
        return r;
    endfunction

    function automatic llca_div_t div_step(input llca_div_t d, input int b);
        llca_div_t       r;
        logic [R_W-1:0]  sh;
        r  = d;
        sh = d.den << b;
        if (d.rem >= sh)
        begin
            r.rem    = d.rem - sh;
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [OUT_W:0] div_final(input llca_div_t d);
        logic [OUT_W-1:0] lim;
        logic             sat;
        logic [OUT_W-1:0] val;
        lim = d.neg ? LIM_NEG : LIM_POS;
        sat = d.ovf | (d.quo > lim);
        val = sat ? lim : d.quo;
        return {sat, (d.neg ? OUT_W'(-val) : val)};
    endfunction

    // Stage 1: coordinate differences.
    logic signed [COORD_BITS-1:0] a0 [3];
    logic signed [COORD_BITS-1:0] a1 [3];
    logic signed [COORD_BITS-1:0] b0 [3];
    logic signed [COORD_BITS-1:0] b1 [3];
    logic signed [DIFF_W-1:0]     u_reg [3];
    logic signed [DIFF_W-1:0]     v_reg [3];
    logic signed [DIFF_W-1:0]     w_reg [3];
    logic                         v1_reg;

    // Stage 2..6 payload.
    logic signed [PROD_W-1:0] prod_reg [15];
    logic signed [DOT_W-1:0]  dot_reg [5];
    llca_pp_t                 pp_reg [NPAIR];
    logic signed [WP_W-1:0]   wp_reg [NPAIR];
    logic signed [WD_W-1:0]   denom_reg;
    logic signed [WD_W-1:0]   ns_reg;
    logic signed [WD_W-1:0]   nt_reg;
    logic signed [WD_W-1:0]   pn4_reg;
    logic signed [WD_W-1:0]   pd4_reg;
    logic signed [WD_W-1:0]   pn5_reg;
    logic signed [WD_W-1:0]   pd5_reg;
    logic signed [WD_W-1:0]   pn6_reg;
    logic signed [WD_W-1:0]   pd6_reg;
    logic                     dg4_reg;
    logic                     dg5_reg;
    logic                     dg6_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     v4_reg;
    logic                     v5_reg;
    logic                     v6_reg;

    // Divider: stage 0 holds prepared operands, stage 1 the overflow check,
    // stage k+1 holds bit OUT_W-k done.
    llca_div_t ds_reg [OUT_W+2];
    llca_div_t dt_reg [OUT_W+2];
    llca_ctl_t ctl_reg [OUT_W+2];
    logic      dv_reg [OUT_W+2];

    logic       par_next;
    llca_div_t  ds_next;
    llca_div_t  dt_next;
    llca_div_t  ds_chk;
    llca_div_t  dt_chk;
    logic [OUT_W:0] fs;
    logic [OUT_W:0] ft;
    llca_rsp_t  rsp_next;
    llca_rsp_t  rsp_reg;
    logic       done_reg;

    assign busy = 1'b0;

    always_comb
    begin
        a0[0] = req.line_a_start_x; a0[1] = req.line_a_start_y; a0[2] = req.line_a_start_z;
        a1[0] = req.line_a_end_x;   a1[1] = req.line_a_end_y;   a1[2] = req.line_a_end_z;
        b0[0] = req.line_b_start_x; b0[1] = req.line_b_start_y; b0[2] = req.line_b_start_z;
        b1[0] = req.line_b_end_x;   b1[1] = req.line_b_end_y;   b1[2] = req.line_b_end_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i] <= DIFF_W'(a1[i]) - DIFF_W'(a0[i]);
            v_reg[i] <= DIFF_W'(b1[i]) - DIFF_W'(b0[i]);
            w_reg[i] <= DIFF_W'(a0[i]) - DIFF_W'(b0[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i]      <= PROD_W'(u_reg[i]) * PROD_W'(u_reg[i]);
            prod_reg[3 + i]  <= PROD_W'(v_reg[i]) * PROD_W'(v_reg[i]);
            prod_reg[6 + i]  <= PROD_W'(u_reg[i]) * PROD_W'(v_reg[i]);
            prod_reg[9 + i]  <= PROD_W'(w_reg[i]) * PROD_W'(u_reg[i]);
            prod_reg[12 + i] <= PROD_W'(w_reg[i]) * PROD_W'(v_reg[i]);
        end
        for (int k = 0; k < 5; k++)
        begin
            dot_reg[k] <= DOT_W'(prod_reg[3*k]) + DOT_W'(prod_reg[3*k + 1])
                          + DOT_W'(prod_reg[3*k + 2]);
        end
        for (int k = 0; k < NPAIR; k++)
        begin
            pp_reg[k] <= split_mul(dot_reg[PA_IDX[k]], dot_reg[PB_IDX[k]]);
            wp_reg[k] <= join_pp(pp_reg[k]);
        end
        // Parallel case: t = (2*wv + uv) / (2*vv).
        pn4_reg   <= (WD_W'(dot_reg[4]) <<< 1) + WD_W'(dot_reg[2]);
        pd4_reg   <= WD_W'(dot_reg[1]) <<< 1;
        dg4_reg   <= (dot_reg[0] == '0) | (dot_reg[1] == '0);
        pn5_reg   <= pn4_reg;
        pd5_reg   <= pd4_reg;
        dg5_reg   <= dg4_reg;
        pn6_reg   <= pn5_reg;
        pd6_reg   <= pd5_reg;
        dg6_reg   <= dg5_reg;
        denom_reg <= WD_W'(wp_reg[0]) - WD_W'(wp_reg[1]);
        ns_reg    <= WD_W'(wp_reg[2]) - WD_W'(wp_reg[3]);
        nt_reg    <= WD_W'(wp_reg[4]) - WD_W'(wp_reg[5]);
    end

    always_comb
    begin
        par_next = (denom_reg == '0);
        ds_next  = div_init(ns_reg, denom_reg);
        dt_next  = par_next ? div_init(pn6_reg, pd6_reg) : div_init(nt_reg, denom_reg);
    end

    // Quotients of 2^32 or more saturate outright.
    always_comb
    begin
        ds_chk     = ds_reg[0];
        ds_chk.ovf = ds_reg[0].rem >= (ds_reg[0].den << OUT_W);
        dt_chk     = dt_reg[0];
        dt_chk.ovf = dt_reg[0].rem >= (dt_reg[0].den << OUT_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < OUT_W + 2; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v6_reg;
            for (int k = 1; k < OUT_W + 2; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            done_reg <= dv_reg[OUT_W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg[0].degen <= dg6_reg;
        ctl_reg[0].par   <= par_next;
        ds_reg[0]        <= ds_next;
        dt_reg[0]        <= dt_next;
        ctl_reg[1]       <= ctl_reg[0];
        ds_reg[1]        <= ds_chk;
        dt_reg[1]        <= dt_chk;
        for (int k = 1; k < OUT_W + 1; k++)
        begin
            ctl_reg[k+1].degen <= ctl_reg[k].degen;
            ctl_reg[k+1].par   <= ctl_reg[k].par;
            ds_reg[k+1]        <= div_step(ds_reg[k], OUT_W - k);
            dt_reg[k+1]        <= div_step(dt_reg[k], OUT_W - k);
        end
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        fs       = div_final(ds_reg[OUT_W+1]);
        ft       = div_final(dt_reg[OUT_W+1]);
        rsp_next = '0;
        if (ctl_reg[OUT_W+1].degen)
        begin
            rsp_next.param_a   = HALF_FX;
            rsp_next.param_b   = HALF_FX;
            rsp_next.status    = STATUS_ZERO_LEN;
            rsp_next.saturated = 1'b0;
        end
        else if (ctl_reg[OUT_W+1].par)
        begin
            rsp_next.param_a   = HALF_FX;
            rsp_next.param_b   = ft[OUT_W-1:0];
            rsp_next.status    = STATUS_PARALLEL;
            rsp_next.saturated = ft[OUT_W];
        end
        else
        begin
            rsp_next.param_a   = fs[OUT_W-1:0];
            rsp_next.param_b   = ft[OUT_W-1:0];
            rsp_next.status    = STATUS_NORMAL;
            rsp_next.saturated = fs[OUT_W] | ft[OUT_W];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire
